### hw/rtl/dbe_pkg.sv
// Package for the dissemination barrier engine: widths, codes, controller
// state type and the command/status structs between controller and datapath.
// No dependencies.
package dbe_pkg;

  localparam int MAX_ROUNDS = 16;
  localparam int RND_W      = 4;   // slot / round index
  localparam int CNT_W      = 5;   // round count, up to MAX_ROUNDS
  localparam int GRP_W      = 17;
  localparam int NODE_W     = 16;
  localparam int BASE_W     = 48;
  localparam int VAL_W      = 64;
  localparam int SENSE_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int DIV_CNT_W  = 5;   // counts the GRP_W remainder steps

  localparam logic [VAL_W-1:0] SLOT_RESET = 64'h0000_0000_dead_beef;
  localparam int SLOT_SHIFT = 3;   // eight bytes per slot

  typedef enum logic {
    OP_START  = 1'b0,
    OP_ARRIVE = 1'b1
  } op_t;

  typedef enum logic {
    KIND_TOUCH = 1'b0,
    KIND_DONE  = 1'b1
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GROUP_SIZE = 2'd0,
    CFG_OWN_NODE   = 2'd1,
    CFG_SLOT_BASE  = 2'd2,
    CFG_UNUSED     = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DLOAD,
    S_DIV,
    S_EMIT,
    S_CHECK,
    S_DONE,
    S_SOLO
  } state_t;

  typedef struct packed {
    logic write_slot;   // store arrival value
    logic start_bar;    // open a barrier: rounds, round 0, stride 1
    logic advance;      // next round, stride doubles
    logic div_start;    // target node remainder
    logic emit_touch;
    logic emit_done;
    logic finish;       // clear used slots, back to idle phase
  } dbe_cmd_t;

  typedef struct packed {
    logic arrive;       // input item is an arrival
    logic phase;        // barrier in progress
    logic rounds_zero;  // single node group
    logic hit;          // own slot of current round holds the stride
    logic final_round;  // current round is the last one
    logic div_done;
    logic out_free;     // output register can take a result this cycle
  } dbe_status_t;

endpackage

### hw/rtl/dissemination_barrier_engine_unit.sv
// Dissemination barrier engine, top level; items are taken one at a time, a new one
// only when idle, after the previous one is through. Start: load, bit-serial remainder
// for the target node, emit of the first touch; each further satisfied round repeats
// check, load, remainder, emit; a done follows the last check (only a done for one
// node). Arrival: write and check; a completed round goes on into that loop. Stalls hold emits.
// Sync active-low reset: idle, slots 0xdeadbeef, group 1, node 0, base 0. Uses dbe_pkg.
module dissemination_barrier_engine_unit
  import dbe_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BASE_W-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_op,
  input  logic [RND_W-1:0]     in_arrive_round,
  input  logic [VAL_W-1:0]     in_arrive_value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_kind,
  output logic [RND_W-1:0]     out_touch_round,
  output logic [NODE_W-1:0]    out_target_node,
  output logic [SENSE_W-1:0]   out_sense_value,
  output logic [BASE_W-1:0]    out_slot_address,
  output logic                 out_last
);

  dbe_cmd_t    cmd;
  dbe_status_t status;
  state_t      state;

  assign cfg_ready = 1'b1;

  dbe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd),
    .state    (state)
  );

  dbe_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_op            (in_op),
    .in_arrive_round  (in_arrive_round),
    .in_arrive_value  (in_arrive_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_touch_round  (out_touch_round),
    .out_target_node  (out_target_node),
    .out_sense_value  (out_sense_value),
    .out_slot_address (out_slot_address),
    .out_last         (out_last)
  );

  // a done result closes the item
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_DONE) |-> out_last)
    else $error("done result without last");

  // sense written remotely is always 2^round
  a_touch_sense: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_TOUCH) |->
      out_sense_value == (SENSE_W'(1) << out_touch_round))
    else $error("touch sense does not match round");

  // input is only taken with the controller idle
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |-> state == S_IDLE && !cmd.emit_touch && !cmd.emit_done)
    else $error("item taken while busy");

  // a remainder start leaves the controller in S_DIV with the done flag cleared
  a_div_then_emit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> state == S_DIV && !status.div_done)
    else $error("remainder unit done flag not cleared on start");

endmodule

### hw/rtl/dbe_rem.sv
// Bit-serial remainder unit, one dividend bit per cycle (restoring).
// Depends on dbe_pkg.
module dbe_rem
  import dbe_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [GRP_W-1:0] dividend,
  input  logic [GRP_W-1:0] divisor,
  output logic             done,
  output logic [GRP_W-1:0] rem
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [GRP_W-1:0]     quo_r, quo_nxt;
  logic [GRP_W-1:0]     rem_r, rem_nxt;
  logic [GRP_W-1:0]     div_r, div_nxt;
  logic [GRP_W:0]       trial;

  assign trial = {rem_r, quo_r[GRP_W-1]};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = done_r;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (start) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      div_nxt  = divisor;
    end else if (busy_r) begin
      // trial < 2*divisor, so one subtract keeps rem below divisor
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = GRP_W'(trial - {1'b0, div_r});
      end else begin
        rem_nxt = trial[GRP_W-1:0];
      end
      quo_nxt = {quo_r[GRP_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(GRP_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

### hw/rtl/dbe_datapath.sv
// Datapath: config registers, round state, flag slots, remainder unit and
// the output register. Depends on dbe_pkg and dbe_rem.
module dbe_datapath
  import dbe_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  dbe_cmd_t             cmd,
  output dbe_status_t          status,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BASE_W-1:0]    cfg_data,
  input  logic                 in_op,
  input  logic [RND_W-1:0]     in_arrive_round,
  input  logic [VAL_W-1:0]     in_arrive_value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_kind,
  output logic [RND_W-1:0]     out_touch_round,
  output logic [NODE_W-1:0]    out_target_node,
  output logic [SENSE_W-1:0]   out_sense_value,
  output logic [BASE_W-1:0]    out_slot_address,
  output logic                 out_last
);

  logic [GRP_W-1:0]  group_r;
  logic [NODE_W-1:0] own_r;
  logic [BASE_W-1:0] base_r;

  logic              phase_r, phase_nxt;
  logic [RND_W-1:0]  cur_r, cur_nxt;
  logic [CNT_W-1:0]  total_r, total_nxt;
  logic [GRP_W-1:0]  stride_r, stride_nxt;
  logic [VAL_W-1:0]  slot_r [MAX_ROUNDS];

  logic [GRP_W-1:0]  g_eff, g_m1;
  logic [CNT_W-1:0]  bit_len, rounds;
  logic [GRP_W-1:0]  div_dividend, rem;
  logic              div_done;

  logic                ov_r;
  logic                o_kind_r;
  logic [RND_W-1:0]    o_round_r;
  logic [NODE_W-1:0]   o_target_r;
  logic [SENSE_W-1:0]  o_sense_r;
  logic [BASE_W-1:0]   o_addr_r;
  logic                o_last_r;
  logic                hit;
  cfg_idx_t            cfg_sel;

  // ceil(log2(g)) = bit length of g-1, saturated
  always_comb begin
    g_eff   = (group_r == '0) ? GRP_W'(1) : group_r;
    g_m1    = g_eff - 1'b1;
    bit_len = '0;
    for (int i = 0; i < GRP_W; i++) begin
      if (g_m1[i]) bit_len = CNT_W'(i + 1);
    end
    rounds = (bit_len > CNT_W'(MAX_ROUNDS)) ? CNT_W'(MAX_ROUNDS) : bit_len;
  end

  assign hit = phase_r && (slot_r[cur_r] == {{(VAL_W-GRP_W){1'b0}}, stride_r});

  assign cfg_sel = cfg_idx_t'(cfg_index);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_r <= GRP_W'(1);
      own_r   <= '0;
      base_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_sel)
        CFG_GROUP_SIZE: group_r <= cfg_data[GRP_W-1:0];
        CFG_OWN_NODE:   own_r   <= cfg_data[NODE_W-1:0];
        CFG_SLOT_BASE:  base_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    cur_nxt    = cur_r;
    total_nxt  = total_r;
    stride_nxt = stride_r;
    if (cmd.start_bar) begin
      phase_nxt  = 1'b1;
      cur_nxt    = '0;
      total_nxt  = rounds;
      stride_nxt = GRP_W'(1);
    end else if (cmd.advance) begin
      cur_nxt    = cur_r + 1'b1;
      stride_nxt = {stride_r[GRP_W-2:0], 1'b0};
    end else if (cmd.finish) begin
      phase_nxt  = 1'b0;
      cur_nxt    = '0;
      stride_nxt = GRP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= 1'b0;
      cur_r    <= '0;
      total_r  <= '0;
      stride_r <= GRP_W'(1);
      for (int i = 0; i < MAX_ROUNDS; i++) slot_r[i] <= SLOT_RESET;
    end else begin
      phase_r  <= phase_nxt;
      cur_r    <= cur_nxt;
      total_r  <= total_nxt;
      stride_r <= stride_nxt;
      if (cmd.write_slot) begin
        slot_r[in_arrive_round] <= in_arrive_value;
      end else if (cmd.finish) begin
        for (int i = 0; i < MAX_ROUNDS; i++) begin
          if (CNT_W'(i) < total_r) slot_r[i] <= SLOT_RESET;
        end
      end
    end
  end

  // touch rounds keep stride at or below 2^15, so the sum fits
  assign div_dividend = {1'b0, own_r} + stride_r;

  dbe_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (g_eff),
    .done     (div_done),
    .rem      (rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.emit_touch || cmd.emit_done) begin
      ov_r <= 1'b1;
    end else if (!out_stall) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_touch) begin
      o_kind_r   <= KIND_TOUCH;
      o_round_r  <= cur_r;
      o_target_r <= rem[NODE_W-1:0];
      o_sense_r  <= stride_r[SENSE_W-1:0];
      o_addr_r   <= base_r + {{(BASE_W-RND_W-SLOT_SHIFT){1'b0}}, cur_r,
                              {SLOT_SHIFT{1'b0}}};
      o_last_r   <= !hit;  // more rounds follow at once when already satisfied
    end else if (cmd.emit_done) begin
      o_kind_r   <= KIND_DONE;
      o_round_r  <= '0;
      o_target_r <= '0;
      o_sense_r  <= '0;
      o_addr_r   <= '0;
      o_last_r   <= 1'b1;
    end
  end

  assign status.arrive      = (in_op == OP_ARRIVE);
  assign status.phase       = phase_r;
  assign status.rounds_zero = (rounds == '0);
  assign status.hit         = hit;
  assign status.final_round = ({1'b0, cur_r} + 1'b1) == total_r;
  assign status.div_done    = div_done;
  assign status.out_free    = !ov_r || !out_stall;

  assign out_valid        = ov_r;
  assign out_kind         = o_kind_r;
  assign out_touch_round  = o_round_r;
  assign out_target_node  = o_target_r;
  assign out_sense_value  = o_sense_r;
  assign out_slot_address = o_addr_r;
  assign out_last         = o_last_r;

endmodule

### hw/rtl/dbe_ctrl.sv
// Controller state machine for the barrier engine: sequences rounds,
// the remainder unit and result emission. Depends on dbe_pkg.
module dbe_ctrl
  import dbe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  dbe_status_t status,
  output dbe_cmd_t    cmd,
  output state_t      state
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (status.arrive) begin
            cmd.write_slot = 1'b1;
            state_nxt      = S_CHECK;
          end else if (status.phase) begin
            state_nxt = S_IDLE;  // start while busy is dropped
          end else if (status.rounds_zero) begin
            state_nxt = S_SOLO;
          end else begin
            cmd.start_bar = 1'b1;
            state_nxt     = S_DLOAD;
          end
        end
      end
      S_DLOAD: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (status.div_done) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit_touch = 1'b1;
          state_nxt      = status.hit ? S_CHECK : S_IDLE;
        end
      end
      S_CHECK: begin
        if (!status.hit) begin
          state_nxt = S_IDLE;
        end else if (status.final_round) begin
          state_nxt = S_DONE;
        end else begin
          cmd.advance = 1'b1;
          state_nxt   = S_DLOAD;
        end
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.emit_done = 1'b1;
          cmd.finish    = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_SOLO: begin
        if (status.out_free) begin
          cmd.emit_done = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign state = state_r;

endmodule

### sim/dbe_barrier_checker.sv
// Scoreboard for the dissemination barrier engine: tracks config writes,
// predicts the touch/done results of every accepted item and compares them
// with the result channel. Depends on dbe_pkg.
module dbe_barrier_checker
  import dbe_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BASE_W-1:0]    cfg_data,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic                 in_op,
  input  logic [RND_W-1:0]     in_arrive_round,
  input  logic [VAL_W-1:0]     in_arrive_value,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic                 out_kind,
  input  logic [RND_W-1:0]     out_touch_round,
  input  logic [NODE_W-1:0]    out_target_node,
  input  logic [SENSE_W-1:0]   out_sense_value,
  input  logic [BASE_W-1:0]    out_slot_address,
  input  logic                 out_last,
  output int                   fail_count,
  output int                   results_seen,
  output int                   results_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    kind_t              kind;
    logic [RND_W-1:0]   rnd;
    logic [NODE_W-1:0]  node;
    logic [SENSE_W-1:0] sense;
    logic [BASE_W-1:0]  addr;
    logic               last;
  } barrier_result_t;

  barrier_result_t predicted_results[$];

  // shadow registers
  logic [GRP_W-1:0]  group_cfg;
  logic [NODE_W-1:0] own_cfg;
  logic [BASE_W-1:0] base_cfg;

  // barrier state
  logic              open_bar;
  logic [CNT_W-1:0]  round_idx;
  logic [CNT_W-1:0]  round_total;
  logic [GRP_W-1:0]  stride;
  logic [VAL_W-1:0]  slots [MAX_ROUNDS];

  initial begin
    fail_count      = 0;
    results_seen    = 0;
    results_pending = 0;
  end

  function automatic barrier_result_t make_touch();
    barrier_result_t t;
    int unsigned     g;
    int unsigned     sum;
    g = (group_cfg == '0) ? 1 : int'(group_cfg);
    sum = own_cfg + stride;
    t.kind  = KIND_TOUCH;
    t.rnd   = round_idx[RND_W-1:0];
    t.node  = NODE_W'(sum % g);
    t.sense = stride[SENSE_W-1:0];
    t.addr  = base_cfg + {round_idx, 3'b000};
    t.last  = 1'b0;
    return t;
  endfunction

  function automatic barrier_result_t make_done();
    barrier_result_t t;
    t = '0;
    t.kind = KIND_DONE;
    return t;
  endfunction

  // walk through every round whose own slot already holds the stride
  task automatic walk_rounds();
    while (open_bar && round_idx < MAX_ROUNDS &&
           slots[round_idx[RND_W-1:0]] == VAL_W'(stride)) begin
      stride = stride << 1;
      round_idx++;
      if (round_idx >= round_total) begin
        for (int i = 0; i < int'(round_total); i++) slots[i] = SLOT_RESET;
        open_bar  = 1'b0;
        round_idx = '0;
        stride    = GRP_W'(1);
        predicted_results.push_back(make_done());
      end else begin
        predicted_results.push_back(make_touch());
      end
    end
  endtask

  task automatic predict_barrier_results(op_t op, logic [RND_W-1:0] r,
                                         logic [VAL_W-1:0] v);
    int              n_before;
    int unsigned     g;
    int              depth;
    barrier_result_t tail;
    n_before = predicted_results.size();
    if (op == OP_ARRIVE) begin
      slots[r] = v;
      walk_rounds();
    end else if (!open_bar) begin
      g = (group_cfg == '0) ? 1 : int'(group_cfg);
      depth = 0;
      while (depth < MAX_ROUNDS && (32'd1 << depth) < g) depth++;
      if (depth == 0) begin
        predicted_results.push_back(make_done());
      end else begin
        round_total = CNT_W'(depth);
        round_idx   = '0;
        stride      = GRP_W'(1);
        open_bar    = 1'b1;
        predicted_results.push_back(make_touch());
        walk_rounds();
      end
    end
    if (predicted_results.size() > n_before) begin
      tail = predicted_results.pop_back();
      tail.last = 1'b1;
      predicted_results.push_back(tail);
    end
  endtask

  task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    barrier_result_t want;
    if (!rst_n) begin
      group_cfg   = GRP_W'(1);
      own_cfg     = '0;
      base_cfg    = '0;
      open_bar    = 1'b0;
      round_idx   = '0;
      round_total = '0;
      stride      = GRP_W'(1);
      for (int i = 0; i < MAX_ROUNDS; i++) slots[i] = SLOT_RESET;
      predicted_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_GROUP_SIZE: group_cfg = cfg_data[GRP_W-1:0];
          CFG_OWN_NODE:   own_cfg   = cfg_data[NODE_W-1:0];
          CFG_SLOT_BASE:  base_cfg  = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        predict_barrier_results(op_t'(in_op), in_arrive_round, in_arrive_value);
      if (out_valid && !out_stall) begin
        results_seen++;
        if (predicted_results.size() == 0) begin
          $error("result with nothing pending: kind %0d round %0d",
                 out_kind, out_touch_round);
          fail_count++;
        end else begin
          want = predicted_results.pop_front();
          compare_field("kind", want.kind, out_kind);
          compare_field("touch_round", want.rnd, out_touch_round);
          compare_field("target_node", want.node, out_target_node);
          compare_field("sense_value", want.sense, out_sense_value);
          compare_field("slot_address", want.addr, out_slot_address);
          compare_field("last", want.last, out_last);
        end
      end
    end
    results_pending <= predicted_results.size();
  end

endmodule

### sim/dissemination_barrier_engine_unit_tb.sv
// Testbench top for the dissemination barrier engine: clock, reset, config
// writes and barrier item traffic; verdict from dbe_barrier_checker.
// Depends on dbe_pkg, dissemination_barrier_engine_unit, dbe_barrier_checker.
module dissemination_barrier_engine_unit_tb;
  import dbe_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_ITEMS  = 118;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [BASE_W-1:0]    cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_op;
  logic [RND_W-1:0]     in_arrive_round;
  logic [VAL_W-1:0]     in_arrive_value;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_kind;
  logic [RND_W-1:0]     out_touch_round;
  logic [NODE_W-1:0]    out_target_node;
  logic [SENSE_W-1:0]   out_sense_value;
  logic [BASE_W-1:0]    out_slot_address;
  logic                 out_last;

  int fail_count;
  int results_seen;
  int results_pending;

  int idle_pct;
  int stall_pct;
  int items_sent;
  int barriers_run;
  logic [GRP_W-1:0] cur_group;

  dissemination_barrier_engine_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_arrive_round  (in_arrive_round),
    .in_arrive_value  (in_arrive_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_touch_round  (out_touch_round),
    .out_target_node  (out_target_node),
    .out_sense_value  (out_sense_value),
    .out_slot_address (out_slot_address),
    .out_last         (out_last)
  );

  dbe_barrier_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_arrive_round  (in_arrive_round),
    .in_arrive_value  (in_arrive_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_touch_round  (out_touch_round),
    .out_target_node  (out_target_node),
    .out_sense_value  (out_sense_value),
    .out_slot_address (out_slot_address),
    .out_last         (out_last),
    .fail_count       (fail_count),
    .results_seen     (results_seen),
    .results_pending  (results_pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk)
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);

  initial begin
    #8_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic [VAL_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic int barrier_depth(logic [GRP_W-1:0] g);
    int d;
    d = 0;
    while (d < MAX_ROUNDS && (32'd1 << d) < g) d++;
    return d;
  endfunction

  task automatic configure(logic [GRP_W-1:0] g, logic [NODE_W-1:0] node,
                           logic [BASE_W-1:0] base);
    logic [BASE_W-1:0] vals [3];
    vals[0] = BASE_W'(g);
    vals[1] = BASE_W'(node);
    vals[2] = base;
    cfg_valid <= 1'b1;
    for (int i = 0; i < 3; i++) begin
      cfg_index <= cfg_idx_t'(i);
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    cur_group = g;
  endtask

  // the sender idles in each cycle with probability idle_pct before an item
  task automatic send_item(op_t op, logic [RND_W-1:0] r, logic [VAL_W-1:0] v);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_op           <= op;
    in_arrive_round <= r;
    in_arrive_value <= v;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // sender holds off until every predicted result is out and the block settles
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_config();
    logic [GRP_W-1:0]  g;
    logic [NODE_W-1:0] node;
    logic [BASE_W-1:0] base;
    case ($urandom_range(9))
      0:       g = '0;
      1:       g = GRP_W'(1);
      2:       g = '1;
      3:       g = 17'd65536;
      4:       g = GRP_W'($urandom_range(2, 131071));
      default: g = GRP_W'($urandom_range(2, 20));
    endcase
    case ($urandom_range(3))
      0:       node = '0;
      1:       node = '1;
      default: node = NODE_W'($urandom);
    endcase
    case ($urandom_range(3))
      0:       base = '0;
      1:       base = '1;
      default: base = BASE_W'(rand_word());
    endcase
    configure(g, node, base);
  endtask

  // one barrier: start, then the correct arrivals in a lightly shuffled order,
  // with wrong-value writes, stray slot writes and ignored starts mixed in
  task automatic run_barrier();
    int               depth;
    int               order [MAX_ROUNDS];
    int               tmp;
    logic [RND_W-1:0] r;
    depth = barrier_depth(cur_group);
    send_item(OP_START, RND_W'($urandom), rand_word());
    if (depth == 0) begin
      if ($urandom_range(2) == 0)
        send_item(OP_ARRIVE, RND_W'($urandom), rand_word());
      return;
    end
    for (int i = 0; i < depth; i++) order[i] = i;
    for (int i = 0; i + 1 < depth; i++) begin
      if ($urandom_range(9) < 3) begin
        tmp = order[i];
        order[i] = order[i+1];
        order[i+1] = tmp;
      end
    end
    for (int k = 0; k < depth; k++) begin
      r = RND_W'(order[k]);
      if ($urandom_range(9) == 0)
        send_item(OP_START, RND_W'($urandom), rand_word());
      if ($urandom_range(4) == 0)
        send_item(OP_ARRIVE, r, rand_word());
      if (depth < MAX_ROUNDS && $urandom_range(9) == 0)
        send_item(OP_ARRIVE, RND_W'($urandom_range(depth, MAX_ROUNDS - 1)),
                  rand_word());
      send_item(OP_ARRIVE, r, VAL_W'(64'd1 << r));
    end
    barriers_run++;
  endtask

  initial begin
    rst_n           = 1'b0;
    cfg_valid       = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    in_valid        = 1'b0;
    in_op           = OP_START;
    in_arrive_round = '0;
    in_arrive_value = '0;
    idle_pct        = 25;
    stall_pct       = 61;
    items_sent      = 0;
    barriers_run    = 0;
    cur_group       = GRP_W'(1);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single node right after reset, then a zero group
    send_item(OP_START, '0, '0);
    settle();
    configure('0, '0, '0);
    send_item(OP_START, '1, '1);

    // arrivals while idle fill every slot with its sense; a start on the
    // largest group then runs all rounds at once
    for (int i = 0; i < MAX_ROUNDS; i++)
      send_item(OP_ARRIVE, RND_W'(i), VAL_W'(64'd1 << i));
    settle();
    configure('1, '1, '1);
    send_item(OP_START, '0, '0);

    // wrong value, start while busy, and a register change mid-barrier
    settle();
    configure(17'd5, 16'd3, 48'h1000);
    send_item(OP_START, '0, '0);
    send_item(OP_ARRIVE, 4'd0, '1);
    send_item(OP_START, '0, '0);
    send_item(OP_ARRIVE, 4'd0, 64'd1);
    settle();
    configure(17'd5, 16'd0, 48'h1000);
    send_item(OP_ARRIVE, 4'd2, 64'd4);
    send_item(OP_ARRIVE, 4'd1, 64'd2);
    settle();

    for (int ph = 0; ph < 3; ph++) begin
      idle_pct  = (ph == 0) ? 25 : (ph == 1) ? 61 : 0;
      stall_pct = (ph == 0) ? 61 : (ph == 1) ? 25 : 0;
      while (items_sent < 25 + (ph + 1) * PHASE_ITEMS) begin
        if ($urandom_range(2) == 0) begin
          settle();
          random_config();
        end
        run_barrier();
      end
    end

    settle();
    $display("Run covered %0d items over %0d random barriers, %0d results checked,",
             items_sent, barriers_run, results_seen);
    $display("group sizes from zero to the maximum, with early and stray arrivals");
    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

### dissemination_barrier_engine_unit.f
hw/rtl/dbe_pkg.sv
hw/rtl/dbe_rem.sv
hw/rtl/dbe_datapath.sv
hw/rtl/dbe_ctrl.sv
hw/rtl/dissemination_barrier_engine_unit.sv
sim/dbe_barrier_checker.sv
sim/dissemination_barrier_engine_unit_tb.sv
